[rtl/cfr_pkg.sv]
// Shared types, constants and CRC/stuffing functions for the bit-stuffing framer.
package cfr_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int ACC_W      = 24;
	localparam int CNT_W      = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_FLAG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 1'b1;

	localparam logic [7:0]  FLAG_RESET = 8'h7E;
	localparam logic [15:0] MAX_RESET  = 16'd4096;
	localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [2:0]  RUN_LIMIT  = 3'd5;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [31:0] fcs;
	} cfr_entry_t;

	typedef struct packed {
		logic [7:0]  flag;
		logic [15:0] max_bytes;
	} cfr_cfg_t;

	typedef struct packed {
		logic [9:0] bits;
		logic [3:0] len;
		logic [2:0] run;
	} cfr_stuff_t;

	typedef enum logic [1:0] {
		PH_DATA,
		PH_FCS,
		PH_TAIL
	} cfr_phase_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

	// stuff one byte MSB first; bits come out right aligned, oldest highest
	function automatic cfr_stuff_t stuff_byte(logic [7:0] b, logic [2:0] run);
		cfr_stuff_t r;
		logic [2:0] k;
		r.bits = '0;
		r.len  = '0;
		k      = run;
		for (int i = 7; i >= 0; i--) begin
			r.bits = {r.bits[8:0], b[i]};
			r.len  = r.len + 4'd1;
			k      = b[i] ? k + 3'd1 : 3'd0;
			if (k == RUN_LIMIT) begin
				r.bits = {r.bits[8:0], 1'b0};
				r.len  = r.len + 4'd1;
				k      = 3'd0;
			end
		end
		r.run = k;
		return r;
	endfunction

endpackage

[rtl/cfr_in_if.sv]
// Input word channel: payload byte with end-of-payload marker.
interface cfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_payload;

	modport source (output valid, output data_byte, output end_of_payload, input ready);
	modport sink (input valid, input data_byte, input end_of_payload, output ready);
endinterface

[rtl/cfr_out_if.sv]
// Output word channel: framed stream byte with frame end and overflow flags.
interface cfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       overflow;

	modport source (output valid, output out_byte, output frame_end, output overflow,
		input ready);
	modport sink (input valid, input out_byte, input frame_end, input overflow,
		output ready);
endinterface

[rtl/cfr_cfg_if.sv]
// Configuration write channel: register index and write data.
interface cfr_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/cfr_front.sv]
// Front end: accepts payload words, marks frame start, runs the CRC, emits queue entries.
module cfr_front (
	input  logic               clk,
	input  logic               arst_n,
	cfr_in_if.sink             din,
	input  logic               full,
	output logic               push,
	output cfr_pkg::cfr_entry_t entry
);
	import cfr_pkg::*;

	logic [31:0] crc_q;
	logic        infrm_q;
	logic [31:0] crc_in;
	logic [31:0] crc_new;

	assign din.ready = !full;
	assign push      = din.valid && !full;
	assign crc_in    = infrm_q ? crc_q : CRC_INIT;
	assign crc_new   = crc_byte(crc_in, din.data_byte);

	always_comb begin
		entry.data  = din.data_byte;
		entry.first = !infrm_q;
		entry.last  = din.end_of_payload;
		entry.fcs   = ~crc_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			infrm_q <= 1'b0;
		end else if (push) begin
			crc_q   <= crc_new;
			infrm_q <= !din.end_of_payload;
		end
	end
endmodule

[rtl/cfr_queue.sv]
// Small FIFO of classified entries between front and back end.
module cfr_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cfr_pkg::cfr_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                valid,
	output cfr_pkg::cfr_entry_t head
);
	import cfr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

	cfr_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [CNT_QW-1:0] cnt_q;
	logic              do_pop;

	assign full   = (cnt_q == FULL_CNT);
	assign valid  = (cnt_q != '0);
	assign head   = mem_q[rptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

[rtl/cfr_back.sv]
// Back end: bit stuffing, packing, length limit, flags and the output register.
module cfr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cfr_pkg::cfr_cfg_t   cfg_regs,
	input  logic                q_valid,
	input  cfr_pkg::cfr_entry_t q_head,
	output logic                q_pop,
	cfr_out_if.source           dout
);
	import cfr_pkg::*;

	cfr_phase_t       ph_q, ph_n;
	logic [1:0]       fidx_q, fidx_n;
	logic [ACC_W-1:0] acc_q, acc_n;
	logic [CNT_W-1:0] cnt_q, cnt_n, cnt_mid;
	logic [2:0]       run_q, run_n;
	logic [15:0]      be_q, be_n;
	logic             ovf_q, ovf_n;
	logic             opened_q, opened_n;

	logic             ov_q;
	logic [7:0]       ob_q;
	logic             ofe_q;
	logic             oovf_q;

	logic             out_free;
	logic             have_byte;
	logic             body_ok;
	logic             take;
	logic [ACC_W-1:0] top_sh;
	logic [ACC_W-1:0] pad_sh;
	logic [31:0]      fcs_sh;
	logic [7:0]       src_byte;
	cfr_stuff_t       st;
	logic             body_try;
	logic [7:0]       body_b;
	logic             emit;
	logic [7:0]       e_byte;
	logic             e_fe;
	logic             e_ov;

	assign out_free  = !ov_q || dout.ready;
	assign have_byte = (cnt_q >= CNT_W'(8));
	assign body_ok   = !ovf_q && (({1'b0, be_q} + 17'd1) < {1'b0, cfg_regs.max_bytes});
	assign top_sh    = acc_q >> (cnt_q - CNT_W'(8));
	assign pad_sh    = acc_q << (CNT_W'(8) - cnt_q);
	assign fcs_sh    = q_head.fcs >> {fidx_q, 3'b000};
	assign src_byte  = (ph_q == PH_DATA) ? q_head.data : fcs_sh[7:0];
	assign st        = stuff_byte(src_byte, run_q);

	always_comb begin
		ph_n     = ph_q;
		fidx_n   = fidx_q;
		acc_n    = acc_q;
		cnt_n    = cnt_q;
		run_n    = run_q;
		be_n     = be_q;
		ovf_n    = ovf_q;
		opened_n = opened_q;
		q_pop    = 1'b0;
		take     = 1'b0;
		cnt_mid  = cnt_q;
		body_try = 1'b0;
		body_b   = top_sh[7:0];
		emit     = 1'b0;
		e_byte   = cfg_regs.flag;
		e_fe     = 1'b0;
		e_ov     = 1'b0;

		if (q_valid) begin
			if (q_head.first && !opened_q) begin
				if (out_free) begin
					emit     = 1'b1;
					opened_n = 1'b1;
					be_n     = 16'd1;
				end
			end else begin
				unique case (ph_q)
					PH_DATA, PH_FCS: begin
						take     = have_byte && out_free;
						body_try = take;
						cnt_mid  = take ? cnt_q - CNT_W'(8) : cnt_q;
						cnt_n    = cnt_mid;
						if (cnt_mid < CNT_W'(8)) begin
							acc_n = (acc_q << st.len) | ACC_W'(st.bits);
							cnt_n = cnt_mid + CNT_W'(st.len);
							run_n = st.run;
							if (ph_q == PH_DATA) begin
								if (q_head.last) begin
									ph_n   = PH_FCS;
									fidx_n = 2'd0;
								end else begin
									q_pop = 1'b1;
								end
							end else if (fidx_q == 2'd3) begin
								ph_n = PH_TAIL;
							end else begin
								fidx_n = fidx_q + 2'd1;
							end
						end
					end
					PH_TAIL: begin
						if (out_free) begin
							if (have_byte) begin
								body_try = 1'b1;
								cnt_n    = cnt_q - CNT_W'(8);
							end else if (cnt_q != '0) begin
								body_try = 1'b1;
								body_b   = pad_sh[7:0];
								cnt_n    = '0;
							end else begin
								emit     = 1'b1;
								e_fe     = 1'b1;
								e_ov     = ovf_q;
								run_n    = '0;
								be_n     = '0;
								ovf_n    = 1'b0;
								opened_n = 1'b0;
								q_pop    = 1'b1;
								ph_n     = PH_DATA;
							end
						end
					end
					default: begin
						ph_n = PH_DATA;
					end
				endcase
			end
		end

		if (body_try) begin
			if (body_ok) begin
				emit   = 1'b1;
				e_byte = body_b;
				be_n   = be_q + 16'd1;
			end else begin
				ovf_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_DATA;
		end else begin
			ph_q <= ph_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fidx_q   <= '0;
			acc_q    <= '0;
			cnt_q    <= '0;
			run_q    <= '0;
			be_q     <= '0;
			ovf_q    <= 1'b0;
			opened_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			fidx_q   <= fidx_n;
			acc_q    <= acc_n;
			cnt_q    <= cnt_n;
			run_q    <= run_n;
			be_q     <= be_n;
			ovf_q    <= ovf_n;
			opened_q <= opened_n;
			if (out_free) begin
				ov_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			ob_q   <= e_byte;
			ofe_q  <= e_fe;
			oovf_q <= e_ov;
		end
	end

	assign dout.valid     = ov_q;
	assign dout.out_byte  = ob_q;
	assign dout.frame_end = ofe_q;
	assign dout.overflow  = oovf_q;
endmodule

[rtl/crc32_bit_stuffed_framer.sv]
// Top level of the CRC-32 bit-stuffing framer: config registers, front end, queue, back end.
// Payload words enter at up to one per cycle while the entry queue (QUEUE_DEPTH entries)
// has room; the front end runs the CRC-32 on each byte in the cycle it is accepted. The
// back end stuffs one byte per cycle while the bit packer has room and moves at most one
// output word per cycle through its output register, overlapping both; a payload byte
// waits while the packer already holds two full bytes, or while the output register
// waits on dout.ready.
// The first byte of a frame waits while the opening flag goes out; a frame end stuffs
// the four FCS bytes (each may wait on a full packer), then emits the tail words one at a
// time: up to two packed bytes, the padded byte and the closing flag.
// Flag value and length limit are written through cfg and take effect on the next frame
// if written while the block is idle.
module crc32_bit_stuffed_framer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	cfr_in_if.sink    din,
	cfr_out_if.source dout,
	cfr_cfg_if.sink   cfg
);
	import cfr_pkg::*;

	cfr_cfg_t   cfg_q;
	cfr_entry_t push_entry;
	cfr_entry_t head;
	logic       push;
	logic       full;
	logic       q_valid;
	logic       q_pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag      <= FLAG_RESET;
			cfg_q.max_bytes <= MAX_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FLAG: cfg_q.flag      <= cfg.data[7:0];
				CFG_MAX:  cfg_q.max_bytes <= cfg.data;
				default:  cfg_q           <= cfg_q;
			endcase
		end
	end

	cfr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.full   (full),
		.push   (push),
		.entry  (push_entry)
	);

	cfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (q_pop),
		.valid      (q_valid),
		.head       (head)
	);

	cfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_q),
		.q_valid  (q_valid),
		.q_head   (head),
		.q_pop    (q_pop),
		.dout     (dout)
	);
endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the CRC-32 bit-stuffing framer: random frames, stalls, config sweeps.
`timescale 1ns / 1ps

module tb_top;
	import cfr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} pay_word_t;

	typedef struct packed {
		logic [7:0] b;
		logic       fe;
		logic       ov;
	} framed_word_t;

	logic clk;
	logic arst_n;

	cfr_in_if  in_ch ();
	cfr_out_if out_ch ();
	cfr_cfg_if cfg_ch ();

	crc32_bit_stuffed_framer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (in_ch),
		.dout   (out_ch),
		.cfg    (cfg_ch)
	);

	pay_word_t    pay_q[$];
	framed_word_t framed_q[$];

	// predictor state and register copies
	logic [31:0] frame_crc;
	logic [2:0]  ones_cnt;
	logic [7:0]  pack_reg;
	int unsigned pack_len;
	bit          frame_open;
	int unsigned emit_cnt;
	bit          frame_ovf;
	logic [7:0]  flag_byte;
	logic [15:0] max_len;

	int unsigned cycles;
	int unsigned err_cnt;
	int unsigned words_in;
	int unsigned words_out;
	int unsigned frames_out;
	int unsigned ovf_frames;
	int unsigned cfg_writes;
	bit          in_acc;
	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned rx_mode;
	pay_word_t   next_word;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_frame_state();
		frame_crc  = CRC_INIT;
		ones_cnt   = '0;
		pack_reg   = '0;
		pack_len   = 0;
		frame_open = 1'b0;
		emit_cnt   = 0;
		frame_ovf  = 1'b0;
	endfunction

	function automatic void push_framed(logic [7:0] b, logic fe, logic ov);
		framed_word_t w;
		w.b  = b;
		w.fe = fe;
		w.ov = ov;
		framed_q.push_back(w);
	endfunction

	// non-flag byte, subject to the length limit (room kept for closing flag)
	function automatic void emit_body(logic [7:0] b);
		if (frame_ovf || emit_cnt + 1 >= max_len) begin
			frame_ovf = 1'b1;
		end else begin
			push_framed(b, 1'b0, 1'b0);
			emit_cnt = emit_cnt + 1;
		end
	endfunction

	function automatic void shift_bit(logic v);
		pack_reg = {pack_reg[6:0], v};
		pack_len = pack_len + 1;
		if (pack_len == 8) begin
			emit_body(pack_reg);
			pack_reg = '0;
			pack_len = 0;
		end
	endfunction

	function automatic void stuff_out(logic [7:0] b);
		for (int i = 7; i >= 0; i--) begin
			shift_bit(b[i]);
			ones_cnt = b[i] ? ones_cnt + 3'd1 : 3'd0;
			if (ones_cnt == RUN_LIMIT) begin
				shift_bit(1'b0);
				ones_cnt = '0;
			end
		end
	endfunction

	function automatic void predict_framed(logic [7:0] d, logic last);
		logic [31:0] fcs;
		if (!frame_open) begin
			clear_frame_state();
			frame_open = 1'b1;
			push_framed(flag_byte, 1'b0, 1'b0);
			emit_cnt = 1;
		end
		frame_crc = frame_crc ^ {24'd0, d};
		for (int k = 0; k < 8; k++) begin
			frame_crc = (frame_crc >> 1) ^ (frame_crc[0] ? CRC_POLY : 32'd0);
		end
		stuff_out(d);
		if (last) begin
			fcs = ~frame_crc;
			for (int k = 0; k < 4; k++) begin
				stuff_out(fcs[8*k +: 8]);
			end
			if (pack_len != 0) begin
				emit_body(pack_reg << (8 - pack_len));
			end
			push_framed(flag_byte, 1'b1, frame_ovf);
			clear_frame_state();
		end
	endfunction

	task automatic queue_word(input logic [7:0] d, input logic last);
		pay_word_t w;
		w.data = d;
		w.last = last;
		pay_q.push_back(w);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == CFG_FLAG) begin
			flag_byte = val[7:0];
		end else begin
			max_len = val;
		end
		cfg_writes = cfg_writes + 1;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pay_q.size() != 0 || in_ch.valid || framed_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic gen_frames(input int n, input int long_len);
		int len;
		logic [7:0] d;
		for (int f = 0; f < n; f++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, long_len) : $urandom_range(1, 5);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 7))
					0: d = 8'hFF;
					1: d = flag_byte;
					2: d = 8'h00;
					3: d = 8'hFF >> $urandom_range(0, 7);
					default: d = 8'($urandom_range(0, 255));
				endcase
				queue_word(d, i == len - 1);
			end
		end
	endtask

	task automatic run_phase(input logic [7:0] fl, input logic [15:0] mx, input int n,
		input int long_len);
		cfg_write(CFG_FLAG, {8'd0, fl});
		cfg_write(CFG_MAX, mx);
		gen_frames(n, long_len);
		wait_idle();
	endtask

	// driver: bursts with random gaps; receiver stall pattern
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_acc) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					in_ch.valid <= 1'b0;
				end else if (pay_q.size() > 0) begin
					next_word = pay_q.pop_front();
					in_ch.valid          <= 1'b1;
					in_ch.data_byte      <= next_word.data;
					in_ch.end_of_payload <= next_word.last;
					if (burst_left > 1) begin
						burst_left = burst_left - 1;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			if (cycles % 97 == 0) begin
				rx_mode = $urandom_range(0, 2);
			end
			case (rx_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				default: out_ch.ready <= ((cycles % 7) < 3);
			endcase
		end
	end

	// monitor: predict on accepted input words, check accepted output words
	always @(posedge clk) begin
		cycles = cycles + 1;
		in_acc <= (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
		if (arst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
			predict_framed(in_ch.data_byte, in_ch.end_of_payload);
			words_in = words_in + 1;
		end
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			words_out = words_out + 1;
			if (out_ch.frame_end === 1'b1) begin
				frames_out = frames_out + 1;
				if (out_ch.overflow === 1'b1) ovf_frames = ovf_frames + 1;
			end
			if (framed_q.size() == 0) begin
				err_cnt = err_cnt + 1;
				if (err_cnt <= 10)
					$display("cycle %0d: unexpected word byte %02h end %0b ovf %0b", cycles,
						out_ch.out_byte, out_ch.frame_end, out_ch.overflow);
			end else begin
				framed_word_t w;
				w = framed_q.pop_front();
				if (out_ch.out_byte !== w.b || out_ch.frame_end !== w.fe ||
					out_ch.overflow !== w.ov) begin
					err_cnt = err_cnt + 1;
					if (err_cnt <= 10)
						$display("cycle %0d: expected byte %02h end %0b ovf %0b, got %02h end %0b ovf %0b",
							cycles, w.b, w.fe, w.ov, out_ch.out_byte, out_ch.frame_end,
							out_ch.overflow);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles, framed_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n              = 1'b0;
		in_ch.valid         = 1'b0;
		in_ch.data_byte     = '0;
		in_ch.end_of_payload = 1'b0;
		out_ch.ready        = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		cycles     = 0;
		err_cnt    = 0;
		words_in   = 0;
		words_out  = 0;
		frames_out = 0;
		ovf_frames = 0;
		cfg_writes = 0;
		in_acc     = 1'b0;
		burst_left = 4;
		gap_left   = 0;
		rx_mode    = 0;
		flag_byte  = FLAG_RESET;
		max_len    = MAX_RESET;
		clear_frame_state();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(posedge clk);

		// directed, reset register values
		queue_word(8'h00, 1'b1);
		queue_word(8'hFF, 1'b1);
		queue_word(8'hFF, 1'b0);
		queue_word(8'hFF, 1'b0);
		queue_word(8'hFF, 1'b0);
		queue_word(8'hFF, 1'b1);
		queue_word(8'h7E, 1'b1);
		queue_word(8'h55, 1'b0);
		queue_word(8'hAA, 1'b0);
		queue_word(8'h1F, 1'b0);
		queue_word(8'hF8, 1'b1);
		queue_word(8'h01, 1'b0);
		queue_word(8'h80, 1'b1);
		queue_word(8'h3E, 1'b0);
		queue_word(8'h7C, 1'b1);
		wait_idle();

		gen_frames(10, 24);
		wait_idle();
		run_phase(8'hFF, 16'hFFFF, 8, 30);
		run_phase(8'h00, 16'd2, 4, 12);
		run_phase(8'($urandom_range(0, 255)), 16'd1, 3, 12);
		run_phase(8'($urandom_range(0, 255)), 16'd0, 3, 12);
		run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(3, 12)), 10, 20);
		run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(13, 40)), 9, 30);
		run_phase(FLAG_RESET, MAX_RESET, 8, 24);

		if (framed_q.size() != 0) begin
			err_cnt = err_cnt + 1;
			$display("%0d expected words never arrived", framed_q.size());
		end
		$display("Run covered %0d payload words and %0d output words in %0d frames (%0d overflowed).",
			words_in, words_out, frames_out, ovf_frames);
		$display("Register writes: %0d, errors: %0d, cycles: %0d.", cfg_writes, err_cnt, cycles);
		if (err_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
